// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcf_pkg
// Types and constants shared by the circle pair collision finder modules.
// ----------------------------------------------------------------------------
package cpcf_pkg;

  localparam int COORD_W = 16;  // signed centre coordinate
  localparam int RAD_W   = 16;  // unsigned radius
  localparam int IDX_W   = 6;   // reported entry index
  localparam int CNT_W   = 7;   // set count and sweep counter
  localparam int LIMIT_W = 6;   // pair limit and hit count
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 2;
  localparam int ENTRY_W = 2 * COORD_W;  // {y, x} per memory entry
  localparam int RSQ_W   = 2 * (RAD_W + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RADIUS_A   = 2'd0;
  localparam logic [CFG_W-1:0] CFG_RADIUS_B   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_PAIR_LIMIT = 2'd2;

  localparam logic [LIMIT_W-1:0] PAIR_LIMIT_RST = 6'd63;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Control from the run sequencer to the pair sweep.
  typedef struct packed {
    logic             start;
    logic             stop;
    logic             adv;
    logic [CNT_W-1:0] na;
    logic [CNT_W-1:0] nb;
  } sweep_ctl_t;

  // Status from the pair sweep back to the run sequencer.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic             busy;
  } sweep_stat_t;

endpackage

// ===== rtl/core/cpcf_ram.sv =====
// ----------------------------------------------------------------------------
// cpcf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cpcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/cpcf_sweep.sv =====
// ----------------------------------------------------------------------------
// cpcf_sweep
// Row-major pair sweep: issues one A/B read pair per cycle unless stalled and runs the
// squared distance test through a short stall-able pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpcf_sweep #(
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpcf_pkg::sweep_ctl_t          ctl,
  input  logic [cpcf_pkg::RAD_W-1:0]    radius_a,
  input  logic [cpcf_pkg::RAD_W-1:0]    radius_b,
  output logic                          rd_en,
  output logic [ADDR_W-1:0]             rd_addr_a,
  output logic [ADDR_W-1:0]             rd_addr_b,
  input  logic [cpcf_pkg::ENTRY_W-1:0]  rd_data_a,
  input  logic [cpcf_pkg::ENTRY_W-1:0]  rd_data_b,
  output cpcf_pkg::sweep_stat_t         stat
);

  localparam int CW = cpcf_pkg::COORD_W;
  localparam int SQ_W = 2 * CW;

  logic                         issuing_r;
  logic [cpcf_pkg::CNT_W-1:0]   i_r, j_r, na_r, nb_r;
  logic                         s1_vld_r, s2_vld_r, s3_vld_r;
  logic [cpcf_pkg::IDX_W-1:0]   s1_ia_r, s1_ib_r, s2_ia_r, s2_ib_r, s3_ia_r, s3_ib_r;
  logic [CW-1:0]                magx_r, magy_r;
  logic [SQ_W-1:0]              sqx_r, sqy_r;
  logic [cpcf_pkg::RSQ_W-1:0]   rsq_r;

  logic [CW-1:0]                magx_nxt, magy_nxt;
  logic [SQ_W-1:0]              sqx_nxt, sqy_nxt;
  logic [cpcf_pkg::RSQ_W-1:0]   rsq_nxt;
  logic [cpcf_pkg::RAD_W:0]     rsum;
  logic [SQ_W:0]                d2;
  logic                         row_end, col_end;

  // Magnitude of a coordinate difference always fits the coordinate width.
  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] p,
                                             input logic [CW-1:0] q);
    logic signed [CW:0] d;
    logic signed [CW:0] m;
    d = $signed({p[CW-1], p}) - $signed({q[CW-1], q});
    m = d[CW] ? -d : d;
    return m[CW-1:0];
  endfunction

  assign rd_en     = ctl.adv;
  assign rd_addr_a = ADDR_W'(i_r);
  assign rd_addr_b = ADDR_W'(j_r);

  assign col_end = (j_r + cpcf_pkg::CNT_W'(1)) == nb_r;
  assign row_end = (i_r + cpcf_pkg::CNT_W'(1)) == na_r;

  always_comb begin
    magx_nxt = abs_diff(rd_data_b[CW-1:0], rd_data_a[CW-1:0]);
    magy_nxt = abs_diff(rd_data_b[2*CW-1:CW], rd_data_a[2*CW-1:CW]);
    sqx_nxt  = SQ_W'(magx_r) * SQ_W'(magx_r);
    sqy_nxt  = SQ_W'(magy_r) * SQ_W'(magy_r);
    rsum     = (cpcf_pkg::RAD_W + 1)'(radius_a) + (cpcf_pkg::RAD_W + 1)'(radius_b);
    rsq_nxt  = cpcf_pkg::RSQ_W'(rsum) * cpcf_pkg::RSQ_W'(rsum);
    d2       = (SQ_W + 1)'(sqx_r) + (SQ_W + 1)'(sqy_r);
  end

  // Control: issue counters and stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      na_r      <= '0;
      nb_r      <= '0;
    end else if (ctl.stop) begin
      issuing_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
    end else if (ctl.start) begin
      issuing_r <= (ctl.na != '0) && (ctl.nb != '0);
      i_r       <= '0;
      j_r       <= '0;
      na_r      <= ctl.na;
      nb_r      <= ctl.nb;
    end else if (ctl.adv) begin
      s1_vld_r <= issuing_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (issuing_r) begin
        if (col_end) begin
          j_r <= '0;
          if (row_end) begin
            issuing_r <= 1'b0;
          end else begin
            i_r <= i_r + cpcf_pkg::CNT_W'(1);
          end
        end else begin
          j_r <= j_r + cpcf_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Datapath stages; they hold while the result side is stalled.
  always_ff @(posedge clk) begin
    rsq_r <= rsq_nxt;
    if (ctl.adv) begin
      s1_ia_r <= i_r[cpcf_pkg::IDX_W-1:0];
      s1_ib_r <= j_r[cpcf_pkg::IDX_W-1:0];
      s2_ia_r <= s1_ia_r;
      s2_ib_r <= s1_ib_r;
      magx_r  <= magx_nxt;
      magy_r  <= magy_nxt;
      s3_ia_r <= s2_ia_r;
      s3_ib_r <= s2_ib_r;
      sqx_r   <= sqx_nxt;
      sqy_r   <= sqy_nxt;
    end
  end

  assign stat.hit  = s3_vld_r && (cpcf_pkg::RSQ_W'(d2) <= rsq_r);
  assign stat.ia   = s3_ia_r;
  assign stat.ib   = s3_ib_r;
  assign stat.busy = issuing_r || s1_vld_r || s2_vld_r || s3_vld_r;

  `ASSERT_IMPLIES(a_issue_in_range, clk, rst_n, issuing_r, (i_r < na_r) && (j_r < nb_r), "sweep index beyond run counts")
  `ASSERT_NEXT(a_idle_stays_idle, clk, rst_n, !stat.busy && !ctl.start, !stat.busy, "sweep became busy without a start")

endmodule

// ===== rtl/core/circle_pair_collision_finder.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_finder
// Loads two sets of circle centres and reports the colliding A/B pairs of a
// run, then a closing hit count.
// ----------------------------------------------------------------------------
// Load items (tuser 0 for set A, 1 for set B) write one in-range slot and are taken one
// per cycle; tuser 3 is dropped. A run item (tuser 2) sweeps A outer, B inner
// over the saturated counts and tests one pair per cycle unless a result waits
// at the output: the sweep issues one read to each of the two set memories per
// cycle, and each pair passes the memory read, difference, square and compare
// stages. The sweep stops early once pair_limit pairs have been
// reported, and it freezes whenever a result waits at the output. The run ends
// with a total transfer that carries tuser and tlast high. No item is taken
// while a run is in progress. The memories are not cleared; only written slots
// may be used by a run.
`include "assert_macros.svh"

module circle_pair_collision_finder #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // entry_index, pos_x, pos_y, count_a, count_b, pad
  input  logic [1:0]  in_tuser,  // mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // index_a, index_b, hit_total, pad
  output logic        out_tuser, // is_total
  output logic        out_tlast
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cpcf_pkg::state_t               state_r, state_nxt;
  logic [cpcf_pkg::RAD_W-1:0]     radius_a_r, radius_b_r;
  logic [cpcf_pkg::LIMIT_W-1:0]   pair_limit_r;
  logic [cpcf_pkg::LIMIT_W-1:0]   hits_r;
  logic                           out_valid_r, is_total_r;
  logic [cpcf_pkg::IDX_W-1:0]     index_a_r, index_b_r;
  logic [cpcf_pkg::LIMIT_W-1:0]   hit_total_r;

  logic [cpcf_pkg::MODE_W-1:0]    in_mode;
  logic [cpcf_pkg::IDX_W-1:0]     in_entry_index;
  logic [cpcf_pkg::COORD_W-1:0]   in_pos_x, in_pos_y;
  logic [cpcf_pkg::CNT_W-1:0]     in_count_a, in_count_b;
  logic                           in_fire, idx_ok, adv, limit_hit, run_end;
  logic                           load_pair, load_total;
  logic [cpcf_pkg::CNT_W-1:0]     na_sat, nb_sat;
  logic [AW-1:0]                  wr_addr, rd_addr_a, rd_addr_b;
  logic [cpcf_pkg::ENTRY_W-1:0]   wr_data, rd_data_a, rd_data_b;
  logic                           rd_en;
  cpcf_pkg::sweep_ctl_t           ctl;
  cpcf_pkg::sweep_stat_t          stat;

  assign in_mode        = in_tuser;
  assign in_entry_index = in_tdata[5:0];
  assign in_pos_x       = in_tdata[21:6];
  assign in_pos_y       = in_tdata[37:22];
  assign in_count_a     = in_tdata[44:38];
  assign in_count_b     = in_tdata[51:45];

  assign in_tready = (state_r == cpcf_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign idx_ok    = 32'(in_entry_index) < MAX_ENTRIES;
  assign wr_addr   = AW'(in_entry_index);
  assign wr_data   = {in_pos_y, in_pos_x};

  assign na_sat = (32'(in_count_a) > MAX_ENTRIES) ? cpcf_pkg::CNT_W'(MAX_ENTRIES) : in_count_a;
  assign nb_sat = (32'(in_count_b) > MAX_ENTRIES) ? cpcf_pkg::CNT_W'(MAX_ENTRIES) : in_count_b;

  assign adv       = !out_valid_r || out_tready;
  assign limit_hit = (hits_r == pair_limit_r);
  assign run_end   = limit_hit || !stat.busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_a_r   <= '0;
      radius_b_r   <= '0;
      pair_limit_r <= cpcf_pkg::PAIR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpcf_pkg::CFG_RADIUS_A:   radius_a_r   <= cfg_wdata;
        cpcf_pkg::CFG_RADIUS_B:   radius_b_r   <= cfg_wdata;
        cpcf_pkg::CFG_PAIR_LIMIT: pair_limit_r <= cfg_wdata[cpcf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpcf_pkg::ST_IDLE: begin
        if (in_fire && (in_mode == cpcf_pkg::MODE_RUN)) begin
          state_nxt = cpcf_pkg::ST_RUN;
        end
      end
      cpcf_pkg::ST_RUN: begin
        if (run_end && adv) begin
          state_nxt = cpcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpcf_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    ctl.start  = 1'b0;
    ctl.stop   = 1'b0;
    ctl.adv    = adv;
    ctl.na     = na_sat;
    ctl.nb     = nb_sat;
    load_pair  = 1'b0;
    load_total = 1'b0;
    case (state_r)
      cpcf_pkg::ST_IDLE: begin
        ctl.start = in_fire && (in_mode == cpcf_pkg::MODE_RUN);
      end
      cpcf_pkg::ST_RUN: begin
        load_pair  = adv && stat.hit && !limit_hit;
        load_total = adv && run_end;
        ctl.stop   = load_total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpcf_pkg::ST_IDLE;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.start) begin
        hits_r <= '0;
      end else if (load_pair) begin
        hits_r <= hits_r + cpcf_pkg::LIMIT_W'(1);
      end
      if (load_pair || load_total) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; a total transfer carries zero indices.
  always_ff @(posedge clk) begin
    if (load_pair) begin
      is_total_r  <= 1'b0;
      index_a_r   <= stat.ia;
      index_b_r   <= stat.ib;
      hit_total_r <= '0;
    end else if (load_total) begin
      is_total_r  <= 1'b1;
      index_a_r   <= '0;
      index_b_r   <= '0;
      hit_total_r <= hits_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = is_total_r;
  assign out_tlast  = is_total_r;
  assign out_tdata  = {6'd0, hit_total_r, index_b_r, index_a_r};

  cpcf_ram #(
    .WIDTH (cpcf_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (in_fire && idx_ok && (in_mode == cpcf_pkg::MODE_LOAD_A)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  cpcf_ram #(
    .WIDTH (cpcf_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (in_fire && idx_ok && (in_mode == cpcf_pkg::MODE_LOAD_B)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  cpcf_sweep #(
    .ADDR_W (AW)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .radius_a  (radius_a_r),
    .radius_b  (radius_b_r),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .stat      (stat)
  );

  `ASSERT_IMPLIES(a_idle_no_tests, clk, rst_n, state_r == cpcf_pkg::ST_IDLE, !stat.busy, "pair tests in flight outside a run")
  `ASSERT_NEXT(a_hits_step, clk, rst_n, state_r == cpcf_pkg::ST_RUN, (hits_r == $past(hits_r)) || (hits_r == $past(hits_r) + 6'd1), "hit count jumped")
  `ASSERT_IMPLIES(a_one_load, clk, rst_n, 1'b1, !(load_pair && load_total), "pair and total loaded together")

endmodule
